@@ hw/rtl/sfc_pkg.sv @@
// Shared types and constants of the segmenting framer.
`default_nettype none
package sfc_pkg;

  localparam int unsigned MAX_FRAMES        = 255;
  localparam int unsigned PAYLOAD_PER_FRAME = 7;
  localparam int unsigned LEN_W             = 11;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_LENGTH   = LEN_W'(MAX_FRAMES * PAYLOAD_PER_FRAME);
  localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(PAYLOAD_PER_FRAME);
  localparam logic [2:0]       CTRL_POS     = 3'(PAYLOAD_PER_FRAME);
  localparam logic [2:0]       LAST_SLOT    = 3'(PAYLOAD_PER_FRAME - 1);
  // ceil(n/7) = ((n + 6) * 9363) >> 16, exact for n + 6 below 2^12
  localparam logic [13:0]      RECIP_7      = 14'd9363;
  localparam logic [11:0]      ROUND_UP_7   = 12'(PAYLOAD_PER_FRAME - 1);

  // One accepted item as classified by the front end
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] slot;
    logic [7:0] frame;
    logic       last_byte;  // closes the message: pad and close the frame
    logic       fills;      // a control byte follows
    logic [7:0] ctrl;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/sfc_front.sv @@
// Front end: takes payload bytes, tracks message state and classifies each item.
`default_nettype none
module sfc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sfc_pkg::LEN_W-1:0]   cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        queue_full,
  output logic                             push,
  output sfc_pkg::entry_t                  entry
);

  logic [sfc_pkg::LEN_W-1:0] payload_length;
  logic [sfc_pkg::LEN_W-1:0] bytes_taken;
  logic [2:0]                slot;
  logic [7:0]                frame;
  logic [7:0]                sum;

  logic [sfc_pkg::LEN_W-1:0] eff_len;
  logic [11:0]               len_up;
  logic [25:0]               prod;
  logic [7:0]                frame_count;
  logic [11:0]               taken_inc;
  logic                      last_byte;
  logic                      fills;
  logic [7:0]                sum_data;
  logic [7:0]                ctrl;
  logic [7:0]                sum_next;

  always_comb begin
    if (payload_length == '0) begin
      eff_len = sfc_pkg::LEN_W'(1);
    end else if (payload_length > sfc_pkg::MAX_LENGTH) begin
      eff_len = sfc_pkg::MAX_LENGTH;
    end else begin
      eff_len = payload_length;
    end
  end

  assign len_up      = {1'b0, eff_len} + sfc_pkg::ROUND_UP_7;
  assign prod        = 26'(len_up) * 26'(sfc_pkg::RECIP_7);
  assign frame_count = prod[23:16];

  assign taken_inc = {1'b0, bytes_taken} + 12'd1;
  assign last_byte = taken_inc >= {1'b0, eff_len};
  assign fills     = last_byte || (slot == sfc_pkg::LAST_SLOT);
  assign sum_data  = sum + data_byte;

  always_comb begin
    priority if (frame == 8'd0) begin
      ctrl = frame_count;
    end else if (last_byte) begin
      ctrl = sum_data;
    end else begin
      ctrl = frame;
    end
  end

  assign sum_next = sum_data + (fills ? ctrl : 8'd0);

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  assign entry.data      = data_byte;
  assign entry.slot      = slot;
  assign entry.frame     = frame;
  assign entry.last_byte = last_byte;
  assign entry.fills     = fills;
  assign entry.ctrl      = ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= sfc_pkg::RESET_LENGTH;
      bytes_taken    <= '0;
      slot           <= '0;
      frame          <= '0;
      sum            <= '0;
    end else begin
      if (cfg_wr_en) begin
        payload_length <= cfg_wr_data;
      end
      if (push) begin
        if (last_byte) begin
          // message done: start over
          bytes_taken <= '0;
          slot        <= '0;
          frame       <= '0;
          sum         <= '0;
        end else begin
          bytes_taken <= taken_inc[sfc_pkg::LEN_W-1:0];
          sum         <= sum_next;
          if (fills) begin
            slot  <= '0;
            frame <= frame + 8'd1;
          end else begin
            slot <= slot + 3'd1;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot != sfc_pkg::CTRL_POS)
    else $error("slot reached the control position");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    push && last_byte |=> bytes_taken == '0 && slot == '0 && frame == '0 && sum == '0)
    else $error("state not cleared after message end");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/sfc_queue.sv @@
// Short queue of classified items between front end and back end.
`default_nettype none
module sfc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sfc_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output sfc_pkg::entry_t      head
);

  sfc_pkg::entry_t                 slots [sfc_pkg::QUEUE_DEPTH];
  logic [sfc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [sfc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [sfc_pkg::QUEUE_CNT_W-1:0] count;

  assign full       = count == sfc_pkg::QUEUE_CNT_W'(sfc_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= sfc_pkg::QUEUE_CNT_W'(sfc_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/sfc_back.sv @@
// Back end: expands each item into payload, padding and control bytes.
`default_nettype none
module sfc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire sfc_pkg::entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic [7:0]           frame_number,
  output logic [2:0]           byte_position,
  output logic                 frame_end,
  output logic                 message_end
);

  logic       started;
  logic [2:0] pos;

  logic [2:0] cur;
  logic       is_ctrl;
  logic       last_out;
  logic       fire;
  logic [7:0] byte_value;

  assign cur      = started ? pos : head.slot;
  assign is_ctrl  = cur == sfc_pkg::CTRL_POS;
  assign last_out = is_ctrl || !head.fills;
  assign fire     = head_valid && (!out_valid || out_ready);
  assign pop      = fire && last_out;

  always_comb begin
    priority if (is_ctrl) begin
      byte_value = head.ctrl;
    end else if (!started) begin
      byte_value = head.data;
    end else begin
      byte_value = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        started   <= !last_out;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos           <= cur + 3'd1;
      out_byte      <= byte_value;
      frame_number  <= head.frame;
      byte_position <= cur;
      frame_end     <= is_ctrl;
      message_end   <= is_ctrl && head.last_byte;
    end
  end

`ifndef SYNTHESIS
  a_msg_end_ctrl: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> frame_end && byte_position == sfc_pkg::CTRL_POS)
    else $error("message end away from a control byte");

  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    started |-> head_valid)
    else $error("item left the queue mid-expansion");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/segmenting_framer_with_checksum_unit.sv @@
// Top level of the segmenting framer with checksum.
// Usage:
//   Write payload_length through cfg_wr_en/cfg_wr_data while the block is idle.
//   Feed the message one data_byte per item on in_valid/in_ready. Each item
//   yields one framed byte, two when it fills a frame (payload plus control
//   byte), and up to eight when it is the final byte of the message (byte,
//   zero padding, closing control byte with message_end).
//   Results leave on out_valid/out_ready with out_byte, frame_number,
//   byte_position, frame_end and message_end.
// Path: an accepted item is written into the queue; the back end then moves its
//   first result from the queue head into the output register.
// Throughput: one result per cycle from the back end while out_ready is high;
//   an item holds the back end until its last result is out. The front end
//   takes an item per cycle while the four-entry queue has room, so in steady
//   state a frame of 7 payload bytes yields 8 output bytes.
// Reset: message state clears, payload_length returns to 7, queue empties.
// Stall: when out_ready is low the output register holds; the queue fills
//   and in_ready drops once all four entries are taken.
`default_nettype none
module segmenting_framer_with_checksum_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [sfc_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                data_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_byte,
  output logic [7:0]                     frame_number,
  output logic [2:0]                     byte_position,
  output logic                           frame_end,
  output logic                           message_end
);

  logic            push;
  logic            queue_full;
  logic            pop;
  logic            head_valid;
  sfc_pkg::entry_t push_entry;
  sfc_pkg::entry_t head;

  sfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .queue_full  (queue_full),
    .push        (push),
    .entry       (push_entry)
  );

  sfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .frame_number  (frame_number),
    .byte_position (byte_position),
    .frame_end     (frame_end),
    .message_end   (message_end)
  );

endmodule
`default_nettype wire
